[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bea_pkg.sv]
package bea_pkg;

  localparam int MASK_W          = 8;
  localparam int TIME_W          = 32;
  localparam int PERIOD_W        = 16;
  localparam int BIDX_W          = 3;
  localparam int MOVE_W          = 2;
  localparam int NUM_BUTTONS_DEF = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

  typedef enum logic [MOVE_W-1:0] {
    MV_PRESSED  = 2'd0,
    MV_STILL    = 2'd1,
    MV_RELEASED = 2'd2
  } move_t;

endpackage

[rtl/button_event_autorepeat.sv]
// Button event generator with auto-repeat. Each input item is one poll: a
// pressed mask (bit i = button i) and the current millisecond time. Buttons are
// scanned in index order and each gives at most one result item: PRESSED on a
// new press (hold 0), a repeat item while held once now - repeat start reaches
// cfg period (repeat start then moves to now), RELEASED on release. hold_ms is
// now - press time, wrapping 32-bit; the final item of a poll has last set, and
// a poll with no change gives no item. Buttons at index 8 and up never have a
// mask bit and are not scanned. A poll goes through accept, one scan step per
// button through the press/repeat time memory and one flush step for the last
// item; the result side holding back stalls the scan and the flush. The scan
// is set by the single read port of the time memory: one button per cycle
// while no item is held back by a full output.
// The repeat period register may be written only while the block is idle.
module button_event_autorepeat #(
  parameter int NUM_BUTTONS = bea_pkg::NUM_BUTTONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bea_pkg::MASK_W-1:0]   in_pressed_mask,
  input  logic [bea_pkg::TIME_W-1:0]   in_now_ms,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bea_pkg::BIDX_W-1:0]   out_button_index,
  output logic [bea_pkg::TIME_W-1:0]   out_hold_ms,
  output logic [bea_pkg::MOVE_W-1:0]   out_movement,
  output logic                         out_last,

  input  logic                         cfg_wr_en,
  input  logic [bea_pkg::PERIOD_W-1:0] cfg_wr_data
);

  // only buttons with a mask bit can ever change state
  localparam int ACTIVE_N = (NUM_BUTTONS < bea_pkg::MASK_W) ? NUM_BUTTONS : bea_pkg::MASK_W;
  localparam int IDX_W    = (ACTIVE_N > 1) ? $clog2(ACTIVE_N) : 1;
  localparam int TW       = bea_pkg::TIME_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ACTIVE_N - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic [bea_pkg::BIDX_W-1:0] idx;
    logic [TW-1:0]              hold;
    bea_pkg::move_t             move;
  } ev_t;

  state_t st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [bea_pkg::MASK_W-1:0]   mask_r;
  logic [TW-1:0]                now_r;
  logic [bea_pkg::PERIOD_W-1:0] period_r;
  logic [ACTIVE_N-1:0]          held_r, held_nxt;

  // pending item: held back one step so the last flag is known
  ev_t  pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;

  // output register
  ev_t  obuf_r, obuf_nxt;
  logic olast_r, olast_nxt;
  logic ov_r, ov_nxt;

  // time memory: {press_time, repeat_start} per button. An entry is read only
  // when its held flag is set, and setting that flag writes it, so the memory
  // needs no clearing.
  logic            ram_we;
  logic [2*TW-1:0] ram_wdata, ram_rdata;
  logic [IDX_W-1:0] ram_raddr;

  logic [TW-1:0] press_t, rep_t, hold_d, since_rep;
  logic pressed, held, repeat_due, ev_hit, at_last, adv, out_free;
  logic push;
  ev_t  push_ev;
  logic push_last;
  ev_t  cur_ev;
  logic [IDX_W-1:0] idx_step;

  assign press_t   = ram_rdata[2*TW-1:TW];
  assign rep_t     = ram_rdata[TW-1:0];
  assign pressed   = mask_r[idx_r];
  assign held      = held_r[idx_r];
  assign hold_d    = now_r - press_t;
  assign since_rep = now_r - rep_t;
  assign repeat_due = since_rep >= TW'(period_r);

  assign out_free = !ov_r || out_ready;
  assign at_last  = (idx_r == IDX_LAST);
  assign idx_step = at_last ? '0 : idx_r + 1'b1;

  // event decode for the button under the scan
  always_comb begin
    ev_hit      = 1'b0;
    cur_ev.idx  = bea_pkg::BIDX_W'(idx_r);
    cur_ev.hold = hold_d;
    cur_ev.move = bea_pkg::MV_PRESSED;
    if (pressed && !held) begin
      ev_hit      = 1'b1;
      cur_ev.hold = '0;
    end else if (pressed && held && repeat_due) begin
      ev_hit      = 1'b1;
      cur_ev.move = bea_pkg::MV_STILL;
    end else if (!pressed && held) begin
      ev_hit      = 1'b1;
      cur_ev.move = bea_pkg::MV_RELEASED;
    end
  end

  // stall only when an item must move out and the output is still full
  assign adv = (st_r == ST_SCAN) && (!ev_hit || !pend_v_r || out_free);

  // writeback of the scanned entry; the next entry is read at the same time,
  // so the two collide only when there is a single button
  assign ram_we    = adv && pressed && (!held || repeat_due);
  assign ram_wdata = {(held ? press_t : now_r), now_r};
  assign ram_raddr = adv ? idx_step : idx_r;

  bea_ram #(
    .WIDTH (2 * TW),
    .DEPTH (ACTIVE_N)
  ) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    held_nxt   = held_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    push       = 1'b0;
    push_ev    = pend_r;
    push_last  = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          held_nxt[idx_r] = pressed;
          if (ev_hit) begin
            push       = pend_v_r;
            pend_nxt   = cur_ev;
            pend_v_nxt = 1'b1;
          end
          idx_nxt = idx_step;
          if (at_last) begin
            st_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          st_nxt = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt    = ov_r;
    obuf_nxt  = obuf_r;
    olast_nxt = olast_r;
    if (push) begin
      ov_nxt    = 1'b1;
      obuf_nxt  = push_ev;
      olast_nxt = push_last;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      idx_r    <= '0;
      held_r   <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
      period_r <= bea_pkg::PERIOD_RESET;
    end else begin
      st_r     <= st_nxt;
      idx_r    <= idx_nxt;
      held_r   <= held_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    obuf_r  <= obuf_nxt;
    olast_r <= olast_nxt;
    if (in_valid && in_ready) begin
      mask_r <= in_pressed_mask;
      now_r  <= in_now_ms;
    end
  end

  assign in_ready         = (st_r == ST_IDLE);
  assign out_valid        = ov_r;
  assign out_button_index = obuf_r.idx;
  assign out_hold_ms      = obuf_r.hold;
  assign out_movement     = obuf_r.move;
  assign out_last         = olast_r;

endmodule

[rtl/bea_ram.sv]
module bea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/bea_checker.sv]
`include "assert_macros.svh"

module bea_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bea_pkg::BIDX_W-1:0]   out_button_index,
  input logic [bea_pkg::TIME_W-1:0]   out_hold_ms,
  input logic [bea_pkg::MOVE_W-1:0]   out_movement,
  input logic                         out_last
);

  // index of the previous item taken, while its poll is still open
  logic [bea_pkg::BIDX_W-1:0] prev_idx_r;
  logic                       open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      prev_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      open_r     <= !out_last;
      prev_idx_r <= out_button_index;
    end
  end

  `ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "item shown right after reset")

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_hold_ms) && $stable(out_button_index) && $stable(out_movement) && $stable(out_last), "stalled item changed")

  `ASSERT_CLK(a_press_zero, out_valid && out_movement == bea_pkg::MV_PRESSED |-> out_hold_ms == '0, "press item with nonzero hold")

  `ASSERT_CLK(a_idx_order, out_valid && out_ready && open_r |-> out_button_index > prev_idx_r, "items of a poll out of button order")

endmodule

bind button_event_autorepeat bea_checker u_bea_checker (.*);

[tb/tb_button_event_autorepeat.sv]
`timescale 1ns / 1ps

module tb_button_event_autorepeat;

  // One expected event: which button, how long it was held, what happened,
  // and whether it closes the poll.
  typedef struct {
    logic [bea_pkg::BIDX_W-1:0] bidx;
    logic [bea_pkg::TIME_W-1:0] hold;
    bea_pkg::move_t             move;
    logic                       last;
  } btn_event_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [bea_pkg::MASK_W-1:0]   in_pressed_mask;
  logic [bea_pkg::TIME_W-1:0]   in_now_ms;
  logic                         out_valid;
  logic                         out_ready;
  logic [bea_pkg::BIDX_W-1:0]   out_button_index;
  logic [bea_pkg::TIME_W-1:0]   out_hold_ms;
  logic [bea_pkg::MOVE_W-1:0]   out_movement;
  logic                         out_last;
  logic                         cfg_wr_en;
  logic [bea_pkg::PERIOD_W-1:0] cfg_wr_data;

  // Shadow of the block state, updated at every accepted poll / cfg write.
  logic [bea_pkg::MASK_W-1:0]   btn_held;
  logic [bea_pkg::TIME_W-1:0]   btn_press_ms [bea_pkg::MASK_W];
  logic [bea_pkg::TIME_W-1:0]   btn_repeat_ms [bea_pkg::MASK_W];
  logic [bea_pkg::PERIOD_W-1:0] period_ms;

  btn_event_t pending_events[$];

  int  error_count    = 0;
  int  events_checked = 0;
  int  polls_accepted = 0;
  int  rx_hold_cycles = 0;   // nonzero: result sink holds out_ready low this long
  bit  no_gaps        = 0;   // both sides run back to back while set

  always #1 clk = ~clk;

  button_event_autorepeat dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pressed_mask  (in_pressed_mask),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_index (out_button_index),
    .out_hold_ms      (out_hold_ms),
    .out_movement     (out_movement),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Event predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_button_state();
    btn_held  = '0;
    period_ms = bea_pkg::PERIOD_RESET;
    for (int i = 0; i < bea_pkg::MASK_W; i++) begin
      btn_press_ms[i]  = '0;
      btn_repeat_ms[i] = '0;
    end
  endfunction

  // Scan buttons low to high; each gives at most one event. Differences are
  // 32-bit and wrap, so a counter rollover does not upset repeat timing.
  function automatic void predict_poll(logic [bea_pkg::MASK_W-1:0] mask,
                                       logic [bea_pkg::TIME_W-1:0] now_v);
    btn_event_t                 poll_events[$];
    btn_event_t                 ev;
    logic [bea_pkg::TIME_W-1:0] since_repeat;
    for (int i = 0; i < bea_pkg::MASK_W; i++) begin
      ev.bidx = bea_pkg::BIDX_W'(i);
      ev.last = 1'b0;
      if (mask[i]) begin
        if (btn_held[i]) begin
          since_repeat = now_v - btn_repeat_ms[i];
          if (since_repeat >= bea_pkg::TIME_W'(period_ms)) begin
            ev.hold = now_v - btn_press_ms[i];
            ev.move = bea_pkg::MV_STILL;
            poll_events.insert(poll_events.size(), ev);
            btn_repeat_ms[i] = now_v;
          end
        end else begin
          // fresh press: hold is zero by definition
          btn_held[i]      = 1'b1;
          btn_press_ms[i]  = now_v;
          btn_repeat_ms[i] = now_v;
          ev.hold = '0;
          ev.move = bea_pkg::MV_PRESSED;
          poll_events.insert(poll_events.size(), ev);
        end
      end else if (btn_held[i]) begin
        btn_held[i] = 1'b0;
        ev.hold = now_v - btn_press_ms[i];
        ev.move = bea_pkg::MV_RELEASED;
        poll_events.insert(poll_events.size(), ev);
      end
    end
    // a quiet poll produces nothing, so no last flag either
    if (poll_events.size() != 0)
      poll_events[poll_events.size()-1].last = 1'b1;
    foreach (poll_events[k])
      pending_events.insert(pending_events.size(), poll_events[k]);
  endfunction

  function automatic void check_field(string field, logic [bea_pkg::TIME_W-1:0] expected,
                                      logic [bea_pkg::TIME_W-1:0] actual);
    if (actual !== expected) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: outputs are sampled on the rising edge. Result check comes
  // before the new poll is predicted; a poll can't produce a result on the
  // very edge it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    btn_event_t exp_ev;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        events_checked++;
        if (pending_events.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected event, expected none, actual button %0d hold %0d mv %0d",
                   $time, out_button_index, out_hold_ms, out_movement);
        end else begin
          exp_ev = pending_events.pop_front();
          check_field("button_index", bea_pkg::TIME_W'(exp_ev.bidx),
                      bea_pkg::TIME_W'(out_button_index));
          check_field("hold_ms", exp_ev.hold, out_hold_ms);
          check_field("movement", bea_pkg::TIME_W'(exp_ev.move),
                      bea_pkg::TIME_W'(out_movement));
          check_field("last", bea_pkg::TIME_W'(exp_ev.last), bea_pkg::TIME_W'(out_last));
        end
      end
      if (cfg_wr_en)
        period_ms = cfg_wr_data;
      if (in_valid && in_ready) begin
        polls_accepted++;
        predict_poll(in_pressed_mask, in_now_ms);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: a random stall before each item, or a long
  // hold-off when one is requested. Ready changes only on the falling edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
        gap = 0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready) && rx_hold_cycles == 0)
        @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Poll driver. Returns on the accepting rising edge with in_valid still
  // high; the next call (or wait_drained) decides on the following falling
  // edge whether valid drops for a gap or carries the next item straight on.
  // ---------------------------------------------------------------------------
  task automatic send_poll(logic [bea_pkg::MASK_W-1:0] mask, logic [bea_pkg::TIME_W-1:0] now_v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_pressed_mask <= mask;
    in_now_ms       <= now_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering polls and wait out every expected event. A quiet poll may
  // still be scanning when the queue empties, so allow a full scan plus slack.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Only call with the block idle (after wait_drained).
  task automatic write_period(logic [bea_pkg::PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed: fresh press, repeat threshold at default period, release of
  // several buttons, time wrap, zero period and the largest period.
  task automatic test_directed();
    send_poll(8'h01, 32'd1000);           // press b0, hold 0
    send_poll(8'h01, 32'd1499);           // one short of the period: quiet
    send_poll(8'h01, 32'd1500);           // exactly the period: repeat
    send_poll(8'h81, 32'd1600);           // press b7
    send_poll(8'h00, 32'd2000);           // release both
    send_poll(8'hFF, 32'hFFFF_FF00);      // all pressed near the wrap
    send_poll(8'hFF, 32'h0000_0100);      // wrapped: 512 ms later, all repeat
    send_poll(8'h55, 32'hFFFF_FFFF);      // time going back reads as huge delta
    send_poll(8'h00, 32'h0000_0000);
    wait_drained();

    write_period(16'd0);                  // zero period: repeat every poll
    send_poll(8'h0F, 32'd7);
    send_poll(8'h0F, 32'd7);              // same timestamp still repeats
    send_poll(8'h0F, 32'd8);
    send_poll(8'hF0, 32'd9);              // four releases then four presses
    send_poll(8'h00, 32'd10);
    wait_drained();

    write_period(16'hFFFF);
    send_poll(8'hAA, 32'd100);
    send_poll(8'hAA, 32'd100 + 32'd65534);
    send_poll(8'hAA, 32'd100 + 32'd65535);
    send_poll(8'h00, 32'hFFFF_FFFF);
    send_poll(8'h00, 32'h0000_0000);      // nothing held, nothing emitted
    wait_drained();
  endtask

  // Mostly realistic key activity: time moves forward by small steps and one
  // bit, a random set or no bit of the mask flips; some polls are pure noise.
  // The sender stops halfway until every event is back.
  task automatic test_key_sessions(logic [bea_pkg::PERIOD_W-1:0] period, int unsigned max_step,
                                   int count);
    logic [bea_pkg::MASK_W-1:0] mask;
    logic [bea_pkg::TIME_W-1:0] now_v;
    int                         pick;
    write_period(period);
    mask  = '0;
    now_v = $urandom();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        if (pick < 4)
          mask ^= bea_pkg::MASK_W'(1) << $urandom_range(0, bea_pkg::MASK_W - 1);
        else if (pick == 4)
          mask ^= bea_pkg::MASK_W'($urandom_range(0, 255));
        now_v += $urandom_range(0, max_step);
      end else begin
        mask  = bea_pkg::MASK_W'($urandom_range(0, 255));
        now_v = $urandom();
      end
      send_poll(mask, now_v);
      if (n == count / 2)
        wait_drained();
    end
    wait_drained();
  endtask

  // Result side holds off for a long time while the sender keeps offering
  // full-press/full-release polls (eight events each), so the block backs up
  // and stalls its input.
  task automatic test_result_backpressure();
    logic [bea_pkg::TIME_W-1:0] now_v;
    now_v = $urandom();
    no_gaps = 1;
    rx_hold_cycles = 300;
    for (int n = 0; n < 24; n++) begin
      now_v += $urandom_range(1, 1000);
      send_poll(n[0] ? 8'h00 : 8'hFF, now_v);
    end
    no_gaps = 0;
    wait_drained();
  endtask

  initial begin : run
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_pressed_mask = '0;
    in_now_ms       = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    clear_button_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_key_sessions(16'd500, 300, 90);
    no_gaps = 1;                                  // back-to-back stretch
    test_key_sessions(16'd0, 5, 70);
    no_gaps = 0;
    test_key_sessions(16'($urandom_range(1, 60)), 60, 90);
    test_key_sessions(16'hFFFF, 40000, 70);
    test_result_backpressure();
    wait_drained();

    $display("Run: %0d polls, %0d button events checked; periods 0, 500, 65535 and random,",
             polls_accepted, events_checked);
    $display("time wrap, noise polls, random stalls on both sides and a 300-cycle hold-off.");
    if (error_count == 0 && pending_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("%0t ns: timeout, %0d events still expected", $time, pending_events.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
